/* src/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types, constants and page navigation for the touch frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int unsigned BUFFER_BYTES = 16;
    localparam int unsigned DECODE_BYTES = 6;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned Q_DEPTH      = 2;
    localparam int unsigned Q_PTR_W      = 1;
    localparam int unsigned Q_CNT_W      = 2;

    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] BYTE_PAGE  = 8'h66;
    localparam logic [7:0] BYTE_TOUCH = 8'h67;
    localparam logic [7:0] BYTE_SLEEP = 8'h68;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PAGE  = 2'd1;
    localparam logic [1:0] KIND_TOUCH = 2'd2;

    localparam logic [3:0] PG_HOME    = 4'd0;
    localparam logic [3:0] PG_PV      = 4'd1;
    localparam logic [3:0] PG_LOAD    = 4'd2;
    localparam logic [3:0] PG_BATTERY = 4'd3;
    localparam logic [3:0] PG_GRID    = 4'd4;
    localparam logic [3:0] PG_SYSTEM  = 4'd5;
    localparam logic [3:0] PG_TODAY   = 4'd6;
    localparam logic [3:0] PG_GAPS    = 4'd7;
    localparam logic [3:0] PG_SETUP   = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  page;
        logic [15:0] x;
        logic [15:0] y;
        logic        pressed;
    } frame_t;

    function automatic logic [3:0] hit_region(
        input logic [3:0]  cur,
        input logic [15:0] x,
        input logic [15:0] y
    );
        logic [3:0] res;
        logic [3:0] col_top;
        logic [3:0] col_bot;
        begin
            res = cur;
            if (x < 16'd161)
            begin
                col_top = PG_PV;
                col_bot = PG_GRID;
            end
            else if (x < 16'd318)
            begin
                col_top = PG_LOAD;
                col_bot = PG_SYSTEM;
            end
            else
            begin
                col_top = PG_BATTERY;
                col_bot = PG_TODAY;
            end
            if (cur == PG_HOME)
            begin
                if (y < 16'd36 && x < 16'd31)
                    res = PG_SETUP;
                else if (y < 16'd44 && x >= 16'd260 && x <= 16'd400)
                    res = PG_GAPS;
                else if (y >= 16'd50 && y <= 16'd153)
                    res = col_top;
                else if (y >= 16'd160 && y <= 16'd271)
                    res = col_bot;
            end
            else if (cur == PG_SYSTEM && x >= 16'd360 && y >= 16'd44 && y < 16'd110)
                res = PG_SETUP;
            else if (cur != PG_SETUP && cur != PG_SYSTEM && x <= 16'd84 && y < 16'd44)
                res = PG_HOME;
            else if (cur == PG_SYSTEM && x <= 16'd84 && y < 16'd44)
                res = PG_HOME;
            return res;
        end
    endfunction

endpackage

/* src/touch_frame_parser_page_nav.sv */
// One byte accepted per cycle while full is low; full rises only while the frame queue holds two frames.
// A frame is classified combinationally and written to the queue when its third end byte is accepted;
// the back register loads it from the queue once that register is empty or being popped.
// A frame takes at least three bytes; the back register drains one result per cycle while it is
// empty or being popped.
// Reset (asynchronous, active low) clears the frame buffer and queue pointers, empties the output, page is home.
// ----------------------------------------------------------------------------
// touch_frame_parser_page_nav
// Touch display frame parser with page navigation.
// ----------------------------------------------------------------------------
module touch_frame_parser_page_nav (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_kind,
    output logic [2:0]  event_page,
    output logic [15:0] touch_x,
    output logic [15:0] touch_y,
    output logic        touch_pressed,
    output logic [3:0]  new_page,
    output logic        page_changed
);
    import tfp_pkg::*;

    logic   accept;
    logic   frame_valid;
    frame_t frame;
    logic   q_full;
    logic   q_empty;
    logic   q_rd;
    frame_t q_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    tfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    tfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_valid),
        .wr_data (frame),
        .full    (q_full),
        .empty   (q_empty),
        .rd_en   (q_rd),
        .rd_data (q_data)
    );

    tfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .event_kind    (event_kind),
        .event_page    (event_page),
        .touch_x       (touch_x),
        .touch_y       (touch_y),
        .touch_pressed (touch_pressed),
        .new_page      (new_page),
        .page_changed  (page_changed)
    );

endmodule

/* src/tfp_front.sv */
// ----------------------------------------------------------------------------
// tfp_front
// Gathers bytes into a frame and classifies it on the third end byte.
// ----------------------------------------------------------------------------
module tfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    output logic            frame_valid,
    output tfp_pkg::frame_t frame
);
    import tfp_pkg::*;

    logic [7:0]       store_reg [DECODE_BYTES];
    logic [7:0]       store_next [DECODE_BYTES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       pend_reg;
    logic [1:0]       pend_next;

    logic [CNT_W-1:0] room;
    logic [1:0]       flush;
    logic [CNT_W-1:0] base;
    logic             fits;
    logic             is_end;
    logic             frame_end;

    assign is_end    = (rx_byte == BYTE_END);
    assign frame_end = accept && is_end && (pend_reg == 2'd2);
    assign room      = CNT_W'(BUFFER_BYTES) - count_reg;
    assign flush     = ({{(CNT_W-2){1'b0}}, pend_reg} > room) ? room[1:0] : pend_reg;
    assign base      = count_reg + {{(CNT_W-2){1'b0}}, flush};
    assign fits      = (base < CNT_W'(BUFFER_BYTES));

    always_comb
    begin
        frame = '0;
        if (count_reg >= CNT_W'(2) && store_reg[0] == BYTE_PAGE
            && store_reg[1] <= 8'(PG_GAPS))
        begin
            frame.kind = KIND_PAGE;
            frame.page = store_reg[1][2:0];
        end
        else if (count_reg >= CNT_W'(DECODE_BYTES)
                 && (store_reg[0] == BYTE_TOUCH || store_reg[0] == BYTE_SLEEP))
        begin
            frame.kind    = KIND_TOUCH;
            frame.x       = {store_reg[1], store_reg[2]};
            frame.y       = {store_reg[3], store_reg[4]};
            frame.pressed = (store_reg[5] != 8'd0);
        end
    end

    assign frame_valid = frame_end;

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        if (accept)
        begin
            if (!is_end)
            begin
                for (int j = 0; j < DECODE_BYTES; j++)
                begin
                    if (CNT_W'(j) >= count_reg && CNT_W'(j) < base)
                        store_next[j] = BYTE_END;
                    else if (CNT_W'(j) == base && fits)
                        store_next[j] = rx_byte;
                end
                count_next = fits ? base + CNT_W'(1) : base;
                pend_next  = pend_reg - flush;
            end
            else if (frame_end)
            begin
                for (int j = 0; j < DECODE_BYTES; j++)
                    store_next[j] = 8'd0;
                count_next = '0;
                pend_next  = '0;
            end
            else
            begin
                pend_next = pend_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DECODE_BYTES; j++)
                store_reg[j] <= 8'd0;
            count_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            store_reg <= store_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

/* src/tfp_queue.sv */
// ----------------------------------------------------------------------------
// tfp_queue
// Short queue of classified frames between the front and back parts.
// ----------------------------------------------------------------------------
module tfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tfp_pkg::frame_t wr_data,
    output logic            full,
    output logic            empty,
    input  logic            rd_en,
    output tfp_pkg::frame_t rd_data
);
    import tfp_pkg::*;

    frame_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + Q_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/tfp_back.sv */
// ----------------------------------------------------------------------------
// tfp_back
// Applies page navigation to each frame and holds the result for the reader.
// ----------------------------------------------------------------------------
module tfp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tfp_pkg::frame_t q_data,
    output logic            q_rd,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      event_kind,
    output logic [2:0]      event_page,
    output logic [15:0]     touch_x,
    output logic [15:0]     touch_y,
    output logic            touch_pressed,
    output logic [3:0]      new_page,
    output logic            page_changed
);
    import tfp_pkg::*;

    logic       valid_reg;
    logic [3:0] page_reg;
    logic [3:0] page_next;
    frame_t     res_reg;
    logic [3:0] new_page_reg;
    logic       changed_reg;

    assign q_rd = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        page_next = page_reg;
        if (q_data.kind == KIND_PAGE)
            page_next = {1'b0, q_data.page};
        else if (q_data.kind == KIND_TOUCH && !q_data.pressed)
            page_next = hit_region(page_reg, q_data.x, q_data.y);
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            res_reg      <= q_data;
            new_page_reg <= page_next;
            changed_reg  <= (page_next != page_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            page_reg  <= PG_HOME;
        end
        else
        begin
            if (q_rd)
            begin
                valid_reg <= 1'b1;
                page_reg  <= page_next;
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    assign empty         = !valid_reg;
    assign event_kind    = res_reg.kind;
    assign event_page    = res_reg.page;
    assign touch_x       = res_reg.x;
    assign touch_y       = res_reg.y;
    assign touch_pressed = res_reg.pressed;
    assign new_page      = new_page_reg;
    assign page_changed  = changed_reg;

endmodule

/* src/tfp_checker.sv */
// ----------------------------------------------------------------------------
// tfp_checker
// Port-level checks on the results of the touch frame parser.
// ----------------------------------------------------------------------------
module tfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  rx_byte,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  event_kind,
    input logic [2:0]  event_page,
    input logic [15:0] touch_x,
    input logic [15:0] touch_y,
    input logic        touch_pressed,
    input logic [3:0]  new_page,
    input logic        page_changed
);
    import tfp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(event_kind) && $stable(new_page))
        else $error("waiting item changed before pop");

    a_page: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && event_kind == KIND_PAGE |-> new_page == {1'b0, event_page})
        else $error("page event did not set page");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && event_kind == KIND_NONE |-> !page_changed && !touch_pressed
            && touch_x == 16'd0 && touch_y == 16'd0 && event_page == 3'd0)
        else $error("unrecognised frame carried data");

    a_press: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && event_kind == KIND_TOUCH && touch_pressed |-> !page_changed)
        else $error("press changed page");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop ##1 !empty && !page_changed |-> new_page == $past(new_page))
        else $error("page moved without change flag");

endmodule

bind touch_frame_parser_page_nav tfp_checker u_tfp_checker (.*);
